>>> sv/pld_pkg.sv
// shared types and constants for the pooled linked deque
// used by every module of the block but pld_ram; no dependencies
package pld_pkg;

	localparam int ACT_W   = 3;
	localparam int VAL_W   = 64;
	localparam int LEN_W   = 4;
	localparam int ROOM_W  = 8;
	localparam int STAT_W  = 3;
	localparam int OCC_W   = 5;
	localparam int NODES_W = 5;
	localparam int BYTES_W = 4;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	typedef logic [VAL_W-1:0]   val_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [ROOM_W-1:0]  room_t;
	typedef logic [OCC_W-1:0]   occ_t;
	typedef logic [NODES_W-1:0] nodes_t;
	typedef logic [BYTES_W-1:0] bytes_t;
	typedef logic [DATA_W-1:0]  word_t;

	localparam nodes_t NODES_RESET = 5'd16;
	localparam bytes_t BYTES_RESET = 4'd8;

	// request codes
	typedef enum logic [ACT_W-1:0] {
		A_PUSH_HEAD = 3'd0,
		A_PUSH_TAIL = 3'd1,
		A_POP_HEAD  = 3'd2,
		A_POP_TAIL  = 3'd3,
		A_REM_HEAD  = 3'd4,
		A_REM_TAIL  = 3'd5,
		A_CLEAR     = 3'd6
	} action_t;

	// result codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_BAD_LEN = 3'd1,
		ST_FULL    = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_SMALL   = 3'd4
	} status_t;

	// register index, taken from address bit 2
	typedef enum logic {
		REG_NODES = 1'b0,
		REG_BYTES = 1'b1
	} reg_t;

	// configuration seen by the sequencer
	typedef struct packed {
		nodes_t nodes_raw;
		bytes_t bytes_raw;
		logic   relink;
	} cfg_t;

	// keep the low len bytes of a little-endian word
	function automatic val_t byte_mask(input len_t len);
		val_t m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (len_t'(i) < len) m[8*i +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

>>> sv/pld_ram.sv
// simple dual-port synchronous memory, one write and one registered read port
// generic; no package dependencies
module pld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

>>> sv/pld_regs.sv
// configuration registers behind the apb-style port
// depends on pld_pkg for register layout and reset values
module pld_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pld_pkg::ADDR_W-1:0]   paddr,
	input  pld_pkg::word_t               pwdata,
	output pld_pkg::word_t               prdata,
	output logic                         pready,
	output pld_pkg::cfg_t                cfg
);

	pld_pkg::nodes_t nodes_q;
	pld_pkg::bytes_t bytes_q;
	logic            wr_en;
	pld_pkg::reg_t   sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign sel    = pld_pkg::reg_t'(paddr[2]);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= pld_pkg::NODES_RESET;
			bytes_q <= pld_pkg::BYTES_RESET;
		end else if (wr_en) begin
			unique case (sel)
				pld_pkg::REG_NODES: nodes_q <= pwdata[pld_pkg::NODES_W-1:0];
				pld_pkg::REG_BYTES: bytes_q <= pwdata[pld_pkg::BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (sel)
			pld_pkg::REG_NODES: prdata = pld_pkg::word_t'(nodes_q);
			pld_pkg::REG_BYTES: prdata = pld_pkg::word_t'(bytes_q);
			default:            prdata = '0;
		endcase
	end

	// any write empties the list
	assign cfg.nodes_raw = nodes_q;
	assign cfg.bytes_raw = bytes_q;
	assign cfg.relink    = wr_en;

endmodule

>>> sv/pld_ctrl.sv
// deque sequencer: pointers, free list, link walk and result register
// depends on pld_pkg; drives the link and item memories
module pld_ctrl #(
	parameter int POOL_NODES = 16,
	parameter int SLOT_BYTES = 8,
	localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1,
	localparam int CW = $clog2(POOL_NODES + 1),
	localparam int SW = 8 * SLOT_BYTES,
	localparam int DW = SW + pld_pkg::LEN_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pld_pkg::cfg_t                  cfg,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [pld_pkg::ACT_W-1:0]      action,
	input  pld_pkg::val_t                  item_value,
	input  pld_pkg::len_t                  item_length,
	input  pld_pkg::room_t                 room_bytes,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [pld_pkg::STAT_W-1:0]     status,
	output pld_pkg::val_t                  popped_value,
	output pld_pkg::len_t                  popped_length,
	output pld_pkg::occ_t                  occupancy,
	output logic                           link_re,
	output logic [PW-1:0]                  link_raddr,
	input  logic [PW:0]                    link_rdata,
	output logic                           link_we,
	output logic [PW-1:0]                  link_waddr,
	output logic [PW:0]                    link_wdata,
	output logic                           data_re,
	output logic [PW-1:0]                  data_raddr,
	input  logic [DW-1:0]                  data_rdata,
	output logic                           data_we,
	output logic [PW-1:0]                  data_waddr,
	output logic [DW-1:0]                  data_wdata
);

	typedef logic [PW:0]    ptr_t;
	typedef logic [PW-1:0]  idx_t;
	typedef logic [CW-1:0]  cnt_t;
	typedef logic [SW-1:0]  slot_t;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_HOLD} state_t;

	localparam ptr_t NIL = {(PW+1){1'b1}};

	state_t state_q, state_d;

	// pointers and free-list fill mark
	ptr_t head_q, head_d, tail_q, tail_d, free_q, free_d;
	cnt_t count_q, count_d, fresh_q, fresh_d;

	// request held for the execute cycle
	pld_pkg::action_t act_q;
	slot_t            val_q;
	pld_pkg::len_t    len_q;
	pld_pkg::room_t   room_q;

	// walk position and popped item carried across the walk
	idx_t          walk_q, walk_d;
	slot_t         pv_q, pv_d;
	pld_pkg::len_t pl_q, pl_d;

	// result waiting for the output register
	pld_pkg::status_t res_status_q;
	slot_t            res_value_q;
	pld_pkg::len_t    res_length_q;

	logic             out_valid_q;
	pld_pkg::status_t out_status_q;
	pld_pkg::val_t    out_value_q;
	pld_pkg::len_t    out_length_q;
	pld_pkg::occ_t    out_occ_q;

	cnt_t             usable;
	pld_pkg::len_t    slot_eff;
	logic             accept, slot_free, fin, fin_load, hold_load, hold_fwd;
	logic             is_pop, at_head, is_fresh;
	pld_pkg::status_t fin_status;
	slot_t            fin_value, pop_value;
	pld_pkg::len_t    fin_length, pop_length, drd_len;
	cnt_t             fresh_inc, count_dec;
	ptr_t             fresh_next, new_head;
	idx_t             free_idx, head_idx, tail_idx;
	pld_pkg::action_t in_act;

	// register limits clamped to the supported range
	always_comb begin
		if (cfg.nodes_raw == '0) usable = cnt_t'(1);
		else if (int'(cfg.nodes_raw) > POOL_NODES) usable = cnt_t'(POOL_NODES);
		else usable = cnt_t'(cfg.nodes_raw);
		if (cfg.bytes_raw == '0) slot_eff = pld_pkg::len_t'(1);
		else if (int'(cfg.bytes_raw) > SLOT_BYTES) slot_eff = pld_pkg::len_t'(SLOT_BYTES);
		else slot_eff = pld_pkg::len_t'(cfg.bytes_raw);
	end

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign slot_free  = !out_valid_q || result_ready;
	assign in_act     = pld_pkg::action_t'(action);

	assign free_idx = free_q[PW-1:0];
	assign head_idx = head_q[PW-1:0];
	assign tail_idx = tail_q[PW-1:0];

	// free list: nodes at or above the fill mark are still in reset order
	assign is_fresh   = (cnt_t'(free_idx) == fresh_q);
	assign fresh_inc  = fresh_q + cnt_t'(1);
	assign fresh_next = (fresh_inc < usable) ? ptr_t'(fresh_inc) : NIL;
	assign count_dec  = (count_q != '0) ? count_q - cnt_t'(1) : count_q;

	assign is_pop     = (act_q == pld_pkg::A_POP_HEAD) || (act_q == pld_pkg::A_POP_TAIL);
	assign at_head    = (act_q == pld_pkg::A_POP_HEAD) || (act_q == pld_pkg::A_REM_HEAD);
	assign drd_len    = data_rdata[SW +: pld_pkg::LEN_W];
	assign pop_value  = is_pop ? data_rdata[SW-1:0] : '0;
	assign pop_length = is_pop ? drd_len : '0;
	// the tail's link is never relied on, so a single item empties the list
	assign new_head   = (head_q == tail_q) ? NIL : link_rdata;

	// sequencer next state and memory accesses
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		free_d     = free_q;
		count_d    = count_q;
		fresh_d    = fresh_q;
		walk_d     = walk_q;
		pv_d       = pv_q;
		pl_d       = pl_q;
		link_re    = 1'b0;
		link_raddr = head_idx;
		data_re    = 1'b0;
		data_raddr = head_idx;
		link_we    = 1'b0;
		link_waddr = free_idx;
		link_wdata = free_q;
		data_we    = 1'b0;
		data_waddr = free_idx;
		data_wdata = {len_q, val_q};
		fin        = 1'b0;
		fin_status = pld_pkg::ST_OK;
		fin_value  = '0;
		fin_length = '0;
		hold_fwd   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
					// start the reads the request needs
					unique case (in_act) inside
						pld_pkg::A_PUSH_HEAD, pld_pkg::A_PUSH_TAIL: begin
							link_re    = !free_q[PW];
							link_raddr = free_idx;
						end
						pld_pkg::A_POP_HEAD, pld_pkg::A_REM_HEAD: begin
							link_re    = !head_q[PW];
							data_re    = !head_q[PW];
						end
						pld_pkg::A_POP_TAIL, pld_pkg::A_REM_TAIL: begin
							link_re    = !head_q[PW];
							data_re    = !tail_q[PW];
							data_raddr = tail_idx;
						end
						default: ;
					endcase
				end
			end

			S_EXEC: begin
				unique case (act_q) inside
					pld_pkg::A_PUSH_HEAD, pld_pkg::A_PUSH_TAIL: begin
						fin = 1'b1;
						if (len_q == '0 || len_q > slot_eff) begin
							fin_status = pld_pkg::ST_BAD_LEN;
						end else if (free_q[PW]) begin
							fin_status = pld_pkg::ST_FULL;
						end else begin
							// take the first free node and store the item
							free_d  = is_fresh ? fresh_next : link_rdata;
							if (is_fresh) fresh_d = fresh_inc;
							data_we = 1'b1;
							count_d = count_q + cnt_t'(1);
							if (act_q == pld_pkg::A_PUSH_HEAD) begin
								link_we    = 1'b1;
								link_wdata = head_q;
								head_d     = free_q;
								if (tail_q[PW]) tail_d = free_q;
							end else begin
								if (!tail_q[PW]) begin
									link_we    = 1'b1;
									link_waddr = tail_idx;
									link_wdata = free_q;
								end
								tail_d = free_q;
								if (head_q[PW]) head_d = free_q;
							end
						end
					end

					pld_pkg::A_POP_HEAD, pld_pkg::A_POP_TAIL,
					pld_pkg::A_REM_HEAD, pld_pkg::A_REM_TAIL: begin
						if (head_q[PW] || tail_q[PW]) begin
							fin        = 1'b1;
							fin_status = pld_pkg::ST_EMPTY;
						end else if (is_pop && pld_pkg::room_t'(drd_len) > room_q) begin
							fin        = 1'b1;
							fin_status = pld_pkg::ST_SMALL;
						end else begin
							pv_d = pop_value;
							pl_d = pop_length;
							if (at_head) begin
								// unlink head and return it to the free list
								fin        = 1'b1;
								fin_value  = pop_value;
								fin_length = pop_length;
								head_d     = new_head;
								if (new_head[PW]) tail_d = NIL;
								link_we    = 1'b1;
								link_waddr = head_idx;
								free_d     = head_q;
								count_d    = count_dec;
							end else if (head_q == tail_q || link_rdata == tail_q ||
								link_rdata[PW]) begin
								// predecessor found without walking
								fin        = 1'b1;
								fin_value  = pop_value;
								fin_length = pop_length;
								if (head_q != tail_q && link_rdata == tail_q) begin
									tail_d = head_q;
								end else begin
									head_d = NIL;
									tail_d = NIL;
								end
								link_we    = 1'b1;
								link_waddr = tail_idx;
								free_d     = tail_q;
								count_d    = count_dec;
							end else begin
								// follow the links toward the tail
								link_re    = 1'b1;
								link_raddr = link_rdata[PW-1:0];
								walk_d     = link_rdata[PW-1:0];
								state_d    = S_WALK;
							end
						end
					end

					pld_pkg::A_CLEAR: begin
						fin     = 1'b1;
						head_d  = NIL;
						tail_d  = NIL;
						free_d  = '0;
						count_d = '0;
						fresh_d = '0;
					end

					default: fin = 1'b1;
				endcase
			end

			S_WALK: begin
				if (link_rdata == tail_q || link_rdata[PW]) begin
					fin        = 1'b1;
					fin_value  = pv_q;
					fin_length = pl_q;
					if (link_rdata == tail_q) begin
						tail_d = {1'b0, walk_q};
					end else begin
						head_d = NIL;
						tail_d = NIL;
					end
					link_we    = 1'b1;
					link_waddr = tail_idx;
					free_d     = tail_q;
					count_d    = count_dec;
				end else begin
					link_re    = 1'b1;
					link_raddr = link_rdata[PW-1:0];
					walk_d     = link_rdata[PW-1:0];
				end
			end

			S_HOLD: begin
				if (slot_free) begin
					hold_fwd = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase

		// finished: straight to the output register, or park the result
		if (fin) state_d = slot_free ? S_IDLE : S_HOLD;

		// configuration write empties the list
		if (cfg.relink) begin
			head_d  = NIL;
			tail_d  = NIL;
			free_d  = '0;
			count_d = '0;
			fresh_d = '0;
		end
	end

	assign fin_load  = fin && slot_free;
	assign hold_load = fin && !slot_free;

	// state, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= NIL;
			tail_q       <= NIL;
			free_q       <= '0;
			count_q      <= '0;
			fresh_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= pld_pkg::ST_OK;
			out_value_q  <= '0;
			out_length_q <= '0;
			out_occ_q    <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			free_q  <= free_d;
			count_q <= count_d;
			fresh_q <= fresh_d;
			if (fin_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= fin_status;
				out_value_q  <= pld_pkg::val_t'(fin_value);
				out_length_q <= fin_length;
				out_occ_q    <= pld_pkg::occ_t'(count_d);
			end else if (hold_fwd) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_value_q  <= pld_pkg::val_t'(res_value_q);
				out_length_q <= res_length_q;
				out_occ_q    <= pld_pkg::occ_t'(count_q);
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= in_act;
			val_q  <= slot_t'(item_value & pld_pkg::byte_mask(item_length));
			len_q  <= item_length;
			room_q <= room_bytes;
		end
		walk_q <= walk_d;
		pv_q   <= pv_d;
		pl_q   <= pl_d;
		if (hold_load) begin
			res_status_q <= fin_status;
			res_value_q  <= fin_value;
			res_length_q <= fin_length;
		end
	end

	assign result_valid  = out_valid_q;
	assign status        = out_status_q;
	assign popped_value  = out_value_q;
	assign popped_length = out_length_q;
	assign occupancy     = out_occ_q;

endmodule

>>> sv/pooled_linked_deque_top.sv
// Deque of items over a pool of linked nodes. Links sit in one synchronous memory and
// items with their lengths in another, both with a registered read port. For a push, a
// head pop or remove, a clear, a rejected request and a tail pop or remove on a list of
// one or two items, the cycle the beat is accepted starts the memory reads, the next one
// checks, writes back and loads the result register. A tail pop or remove on a list of
// k > 2 items walks the links from the head one node per cycle through the link memory
// read port. While the result register waits on result_ready, one more request is still
// taken and executed; its result is parked and item_ready stays low until that result
// moves into the result register. After reset or a register write the free list is
// tracked by a fill mark, so there is no clearing pass.
// depends on pld_pkg, pld_regs, pld_ctrl and pld_ram
module pooled_linked_deque_top #(
	parameter int POOL_NODES = 16,
	parameter int SLOT_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pld_pkg::ADDR_W-1:0]   paddr,
	input  pld_pkg::word_t               pwdata,
	output pld_pkg::word_t               prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [pld_pkg::ACT_W-1:0]    action,
	input  pld_pkg::val_t                item_value,
	input  pld_pkg::len_t                item_length,
	input  pld_pkg::room_t               room_bytes,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [pld_pkg::STAT_W-1:0]   status,
	output pld_pkg::val_t                popped_value,
	output pld_pkg::len_t                popped_length,
	output pld_pkg::occ_t                occupancy
);

	localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int DW = 8 * SLOT_BYTES + pld_pkg::LEN_W;

	pld_pkg::cfg_t cfg;

	logic          link_re, link_we, data_re, data_we;
	logic [PW-1:0] link_raddr, link_waddr, data_raddr, data_waddr;
	logic [PW:0]   link_rdata, link_wdata;
	logic [DW-1:0] data_rdata, data_wdata;

	// configuration registers
	pld_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	pld_ctrl #(
		.POOL_NODES (POOL_NODES),
		.SLOT_BYTES (SLOT_BYTES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.action        (action),
		.item_value    (item_value),
		.item_length   (item_length),
		.room_bytes    (room_bytes),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.status        (status),
		.popped_value  (popped_value),
		.popped_length (popped_length),
		.occupancy     (occupancy),
		.link_re       (link_re),
		.link_raddr    (link_raddr),
		.link_rdata    (link_rdata),
		.link_we       (link_we),
		.link_waddr    (link_waddr),
		.link_wdata    (link_wdata),
		.data_re       (data_re),
		.data_raddr    (data_raddr),
		.data_rdata    (data_rdata),
		.data_we       (data_we),
		.data_waddr    (data_waddr),
		.data_wdata    (data_wdata)
	);

	// next-node links
	pld_ram #(
		.WIDTH (PW + 1),
		.DEPTH (POOL_NODES)
	) u_link_mem (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// item bytes and stored length
	pld_ram #(
		.WIDTH (DW),
		.DEPTH (POOL_NODES)
	) u_data_mem (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.re    (data_re),
		.raddr (data_raddr),
		.rdata (data_rdata)
	);

endmodule

>>> sv/pld_checker.sv
// port-level checks for the pooled linked deque, bound to the top level
// depends on pld_pkg for result codes
module pld_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [pld_pkg::STAT_W-1:0]   status,
	input pld_pkg::val_t                popped_value,
	input pld_pkg::len_t                popped_length,
	input pld_pkg::occ_t                occupancy
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status) &&
		$stable(popped_value) && $stable(popped_length) && $stable(occupancy))
		else $error("result beat changed while stalled");

	// a failed request returns no item
	a_fail_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != pld_pkg::ST_OK |->
		popped_value == '0 && popped_length == '0)
		else $error("item returned with an error status");

	// an empty-list error reports no items
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == pld_pkg::ST_EMPTY |-> occupancy == '0)
		else $error("empty status with items in the list");

	// each request goes through the execute state before the next beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken on consecutive cycles");

endmodule

bind pooled_linked_deque_top pld_checker u_pld_checker (.*);

>>> test/tb_pooled_linked_deque_top.sv
// testbench for pooled_linked_deque_top: directed table, then random request beats checked
// against a deque predictor; register writes between phases; needs pld_pkg and the rtl
`timescale 1ns / 1ps

module tb_pooled_linked_deque_top;
	import pld_pkg::*;

	localparam int POOL_NODES    = 16;
	localparam int SLOT_BYTES    = 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 230;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [ACT_W-1:0] ACT_NONE = 3'd7;

	typedef struct packed {
		status_t st;
		val_t    pv;
		len_t    pl;
		occ_t    occ;
	} result_t;

	typedef struct {
		val_t v;
		len_t l;
	} entry_t;

	typedef struct {
		logic [ACT_W-1:0] act;
		val_t             v;
		len_t             l;
		room_t            room;
		bit               fixed;
		result_t          exp;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [ADDR_W-1:0] paddr;
	word_t            pwdata;
	word_t            prdata;
	logic             pready;
	logic             item_valid;
	logic             item_ready;
	logic [ACT_W-1:0] action;
	val_t             item_value;
	len_t             item_length;
	room_t            room_bytes;
	logic             result_valid;
	logic             result_ready;
	logic [STAT_W-1:0] status;
	val_t             popped_value;
	len_t             popped_length;
	occ_t             occupancy;

	// predictor state
	entry_t  stored_items[$];
	int      pool_cap;
	int      slot_limit;
	result_t pending_results[$];
	row_t    directed_rows[$];
	int      mismatch_count;
	int      cycle_count;
	bit      hold_results;

	pooled_linked_deque_top #(
		.POOL_NODES(POOL_NODES),
		.SLOT_BYTES(SLOT_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.item_value   (item_value),
		.item_length  (item_length),
		.room_bytes   (room_bytes),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.popped_value (popped_value),
		.popped_length(popped_length),
		.occupancy    (occupancy)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// deque behavior for one accepted request beat
	function automatic result_t apply_request(logic [ACT_W-1:0] act, val_t v, len_t l,
			room_t room);
		result_t r;
		entry_t  e;
		bit      at_head;
		r = '0;
		r.st = ST_OK;
		at_head = (act == A_POP_HEAD || act == A_REM_HEAD);
		case (act)
			A_PUSH_HEAD, A_PUSH_TAIL: begin
				if (l == 0 || int'(l) > slot_limit)
					r.st = ST_BAD_LEN;
				else if (stored_items.size() >= pool_cap)
					r.st = ST_FULL;
				else begin
					// bytes past the length are kept as zero
					e.v = (l >= 8) ? v : (v & ((64'd1 << (8 * l)) - 64'd1));
					e.l = l;
					if (act == A_PUSH_HEAD)
						stored_items.push_front(e);
					else
						stored_items.push_back(e);
				end
			end
			A_POP_HEAD, A_POP_TAIL, A_REM_HEAD, A_REM_TAIL: begin
				if (stored_items.size() == 0)
					r.st = ST_EMPTY;
				else begin
					e = at_head ? stored_items[0] : stored_items[$];
					if ((act == A_POP_HEAD || act == A_POP_TAIL) && room < e.l)
						r.st = ST_SMALL;
					else begin
						if (at_head)
							void'(stored_items.pop_front());
						else
							void'(stored_items.pop_back());
						if (act == A_POP_HEAD || act == A_POP_TAIL) begin
							r.pv = e.v;
							r.pl = e.l;
						end
					end
				end
			end
			A_CLEAR: stored_items.delete();
			default: ;
		endcase
		r.occ = occ_t'(stored_items.size());
		return r;
	endfunction

	// register write: saturate and empty the list
	function automatic void apply_register(reg_t idx, word_t d);
		int n;
		if (idx == REG_NODES) begin
			n = int'(d[NODES_W-1:0]);
			pool_cap = (n < 1) ? 1 : (n > POOL_NODES) ? POOL_NODES : n;
		end else begin
			n = int'(d[BYTES_W-1:0]);
			slot_limit = (n < 1) ? 1 : (n > SLOT_BYTES) ? SLOT_BYTES : n;
		end
		stored_items.delete();
	endfunction

	task automatic add_row(logic [ACT_W-1:0] act, val_t v, len_t l, room_t room, bit fixed,
			status_t st, val_t pv, len_t pl, occ_t occ);
		row_t row;
		row.act = act;
		row.v = v;
		row.l = l;
		row.room = room;
		row.fixed = fixed;
		row.exp.st = st;
		row.exp.pv = pv;
		row.exp.pl = pl;
		row.exp.occ = occ;
		directed_rows.push_back(row);
	endtask

	// offer one request beat and record its expected result on acceptance
	task automatic send_request(logic [ACT_W-1:0] act, val_t v, len_t l, room_t room,
			bit fixed, result_t exp);
		result_t r;
		@(negedge clk);
		action = act;
		item_value = v;
		item_length = l;
		room_bytes = room;
		item_valid = 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		r = apply_request(act, v, l, room);
		pending_results.push_back(fixed ? exp : r);
	endtask

	task automatic idle_cycles(int n);
		@(negedge clk);
		item_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// stop offering and wait out every expected result plus the tail walk
	task automatic drain_results();
		idle_cycles(1);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(reg_t idx, word_t d);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		apply_register(idx, d);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// random request, mostly well formed, drifting between filling and draining
	task automatic random_request(inout bit filling, output bit counted);
		logic [ACT_W-1:0] act;
		val_t  v;
		len_t  l;
		room_t room;
		int    r;
		int    occ;
		occ = stored_items.size();
		if (occ == 0)
			filling = 1'b1;
		else if (occ >= pool_cap)
			filling = 1'b0;
		else if ($urandom_range(0, 15) == 0)
			filling = ~filling;
		r = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		l = len_t'($urandom_range(1, slot_limit));
		room = room_t'($urandom_range(8, 255));
		if (r < 4) begin
			// noise over the whole field ranges
			act = ACT_W'($urandom_range(0, 7));
			l = len_t'($urandom_range(0, 15));
			room = room_t'($urandom_range(0, 255));
		end else if (r < 5) begin
			act = A_CLEAR;
		end else if (r < 9) begin
			act = $urandom_range(0, 1) ? A_POP_HEAD : A_POP_TAIL;
			room = room_t'($urandom_range(0, 8));
		end else if (r < 12) begin
			act = $urandom_range(0, 1) ? A_PUSH_HEAD : A_PUSH_TAIL;
			l = $urandom_range(0, 1) ? len_t'(0) : len_t'($urandom_range(slot_limit + 1, 15));
		end else if ((filling && r < 70) || (!filling && r >= 82)) begin
			act = $urandom_range(0, 1) ? A_PUSH_HEAD : A_PUSH_TAIL;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: act = A_POP_HEAD;
				4, 5, 6:    act = A_POP_TAIL;
				7:          act = A_REM_HEAD;
				default:    act = A_REM_TAIL;
			endcase
		end
		send_request(act, v, l, room, 1'b0, '0);
		counted = (act != ACT_NONE);
	endtask

	// result checking
	always @(posedge clk) begin
		result_t exp;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result beat with nothing expected: st %0d val %h len %0d occ %0d",
						status, popped_value, popped_length, occupancy);
			end else begin
				exp = pending_results.pop_front();
				if (status !== exp.st || popped_value !== exp.pv ||
						popped_length !== exp.pl || occupancy !== exp.occ) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp st %0d val %h len %0d occ %0d, got st %0d val %h len %0d occ %0d",
							exp.st, exp.pv, exp.pl, exp.occ,
							status, popped_value, popped_length, occupancy);
				end
			end
		end
	end

	// result side stalls, with one long hold-off on request
	initial begin
		int mode;
		result_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(8, 40)) begin
				@(negedge clk);
				if (hold_results) begin
					result_ready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_results = 1'b0;
				end
				case (mode)
					0:       result_ready = 1'b1;
					1:       result_ready = ($urandom_range(0, 1) == 0);
					2:       result_ready = ($urandom_range(0, 3) == 0);
					default: result_ready = ~result_ready;
				endcase
			end
		end
	end

	// stimulus
	initial begin
		bit    filling;
		bit    counted;
		int    done;
		int    burst_left;
		word_t nodes_word;
		word_t bytes_word;
		row_t  row;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		action = A_CLEAR;
		item_value = '0;
		item_length = '0;
		room_bytes = '0;
		hold_results = 1'b0;
		mismatch_count = 0;
		pool_cap = POOL_NODES;
		slot_limit = SLOT_BYTES;
		filling = 1'b1;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, starting from the reset settings
		add_row(A_POP_HEAD,  '0, 4'd0, 8'd255, 1, ST_EMPTY, '0, 4'd0, 5'd0);
		add_row(A_POP_TAIL,  '0, 4'd0, 8'd255, 1, ST_EMPTY, '0, 4'd0, 5'd0);
		add_row(A_REM_HEAD,  '0, 4'd0, 8'd255, 1, ST_EMPTY, '0, 4'd0, 5'd0);
		add_row(A_REM_TAIL,  '0, 4'd0, 8'd255, 1, ST_EMPTY, '0, 4'd0, 5'd0);
		add_row(A_PUSH_HEAD, '1, 4'd0, 8'd0, 1, ST_BAD_LEN, '0, 4'd0, 5'd0);
		add_row(A_PUSH_TAIL, '1, 4'd9, 8'd0, 1, ST_BAD_LEN, '0, 4'd0, 5'd0);
		add_row(A_PUSH_TAIL, '0, 4'd15, 8'd0, 1, ST_BAD_LEN, '0, 4'd0, 5'd0);
		add_row(A_PUSH_HEAD, '1, 4'd8, 8'd0, 1, ST_OK, '0, 4'd0, 5'd1);
		add_row(A_PUSH_TAIL, 64'h0123_4567_89AB_CDEF, 4'd3, 8'd0, 1, ST_OK, '0, 4'd0, 5'd2);
		add_row(A_PUSH_HEAD, '1, 4'd1, 8'd0, 1, ST_OK, '0, 4'd0, 5'd3);
		add_row(A_POP_TAIL,  '0, 4'd0, 8'd2, 1, ST_SMALL, '0, 4'd0, 5'd3);
		add_row(A_POP_TAIL,  '0, 4'd0, 8'd3, 1, ST_OK, 64'hAB_CDEF, 4'd3, 5'd2);
		add_row(A_POP_HEAD,  '0, 4'd0, 8'd0, 1, ST_SMALL, '0, 4'd0, 5'd2);
		add_row(A_POP_HEAD,  '0, 4'd0, 8'd1, 1, ST_OK, 64'hFF, 4'd1, 5'd1);
		add_row(ACT_NONE,    '1, 4'd8, 8'd255, 1, ST_OK, '0, 4'd0, 5'd1);
		add_row(A_PUSH_TAIL, 64'h8000_0000_0000_0001, 4'd8, 8'd0, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_PUSH_HEAD, 64'hA5A5_5A5A_C3C3_3C3C, 4'd5, 8'd0, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_PUSH_TAIL, 64'hFEDC_BA98_7654_3210, 4'd2, 8'd0, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_REM_TAIL,  '0, 4'd0, 8'd0, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_POP_TAIL,  '0, 4'd0, 8'd8, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_REM_HEAD,  '0, 4'd0, 8'd0, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_POP_HEAD,  '0, 4'd0, 8'd255, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_PUSH_HEAD, 64'h1122_3344_5566_7788, 4'd4, 8'd0, 0, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_CLEAR,     '0, 4'd0, 8'd0, 1, ST_OK, '0, 4'd0, 5'd0);
		add_row(A_REM_TAIL,  '0, 4'd0, 8'd0, 1, ST_EMPTY, '0, 4'd0, 5'd0);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_request(row.act, row.v, row.l, row.room, row.fixed, row.exp);
			if ($urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 4));
		end

		// random phases over several register settings
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				drain_results();
				case (p)
					1: begin nodes_word = 32'd1;          bytes_word = 32'd1; end
					2: begin nodes_word = 32'hFFFF_FFE0;  bytes_word = 32'hFFFF_FFF0; end
					3: begin nodes_word = 32'd31;         bytes_word = 32'd15; end
					4: begin nodes_word = 32'd16;         bytes_word = 32'd8; end
					default: begin
						nodes_word = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 16);
						bytes_word = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 8);
					end
				endcase
				// one phase changes the slot size alone
				if (p != 5)
					write_register(REG_NODES, nodes_word);
				write_register(REG_BYTES, bytes_word);
			end
			done = 0;
			burst_left = $urandom_range(1, 20);
			while (done < PHASE_ITEMS) begin
				if (p == 3 && done == 50)
					hold_results = 1'b1;
				if (p == 6 && done == 100)
					drain_results();
				random_request(filling, counted);
				if (counted)
					done++;
				burst_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 9) < 7)
						idle_cycles($urandom_range(1, 6));
					burst_left = $urandom_range(1, 40);
				end
			end
		end

		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> pooled_linked_deque_top.f
sv/pld_pkg.sv
sv/pld_ram.sv
sv/pld_regs.sv
sv/pld_ctrl.sv
sv/pooled_linked_deque_top.sv
sv/pld_checker.sv
test/tb_pooled_linked_deque_top.sv
